// File: rtl/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and constants of the member table
// Operation and status codes, entry and request records, table geometry.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int STEP_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W       = 64;
  localparam int ADDR_W     = 32;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int MCOUNT_W   = 5;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 168;

  localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_ID   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_ADDR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_INIT  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              pend;
    logic [ID_W-1:0]   id_hi;
    logic [ID_W-1:0]   id_lo;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id_hi;
    logic [ID_W-1:0]   id_lo;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic commit;
    logic commit_ok;
  } cell_ctrl_t;

  typedef struct packed {
    logic local_slot;
    logic placed;
  } head_ctrl_t;

  typedef struct packed {
    logic id_hit;
    logic addr_hit;
    logic place;
  } hit_t;

endpackage

// File: rtl/member_table_cam_top.sv
// ----------------------------------------------------------------------------
// member_table_cam_top: bounded membership table, one operation per request
// Entries rotate through a ring of cells past a single comparator.
// ----------------------------------------------------------------------------
// Flow: add, find and delete on a ready table walk every slot past the head
//   in S_WALK and give the result from S_DONE; init, clear, unused modes and
//   requests on an uninitialized table go from S_IDLE straight to S_DONE.
// One request at a time, taken only in S_IDLE after S_DONE has registered the
//   last result; the one comparator sees each slot once per full ring rotation.
// Reset: synchronous; table uninitialized, all slots invalid, count zero.
module member_table_cam_top
  import mtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // id_high[63:0], id_low[127:64], address[159:128]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode[2:0]
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // found_id_high[63:0], found_id_low[127:64], found_address[159:128],
  // member_count[164:160], zero[167:165]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[2:0]
  output logic [STATUS_W-1:0]   m_tuser
);

  state_t state_q, state_next;

  req_t              req_q;
  req_t              req_in;
  logic [STEP_W-1:0] step_q;
  logic              ready_q;
  logic [COUNT_W-1:0] count_q;

  logic              dup_q;
  logic              placed_q;
  logic              find_hit_q;
  logic              del_hit_q;
  logic [ID_W-1:0]   fnd_hi_q;
  logic [ID_W-1:0]   fnd_lo_q;
  logic [ADDR_W-1:0] fnd_addr_q;

  cell_ctrl_t cctl;
  logic       load0;
  logic       out_fire;
  logic       walk_op;

  entry_t     cell_q [TABLE_DEPTH];
  entry_t     wrap;
  hit_t       hit;
  head_ctrl_t hctl;

  logic [STATUS_W-1:0] status_next;
  logic [COUNT_W-1:0]  count_next;
  logic                ready_next;
  logic [ID_W-1:0]     f_hi;
  logic [ID_W-1:0]     f_lo;
  logic [ADDR_W-1:0]   f_addr;

  assign req_in = '{mode: s_tuser, id_hi: s_tdata[63:0], id_lo: s_tdata[127:64],
                    addr: s_tdata[159:128]};

  assign walk_op = (s_tuser == MODE_ADD) || (s_tuser == MODE_FIND_ID) ||
                   (s_tuser == MODE_FIND_ADDR) || (s_tuser == MODE_DELETE);

  // ring of cells: each takes its right neighbor, the last takes the head's edit
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nb;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nb = wrap;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    mtc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cctl),
      .load     (load0 && (i == 0)),
      .load_req (req_q),
      .shift_in (nb),
      .q        (cell_q[i])
    );
  end

  assign hctl.local_slot = (step_q == '0);
  assign hctl.placed     = placed_q;

  mtc_head u_head (
    .head (cell_q[0]),
    .req  (req_q),
    .hctl (hctl),
    .hit  (hit),
    .wrap (wrap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_next;
    end
  end

  always_comb begin
    state_next = state_q;
    s_tready   = 1'b0;
    cctl       = '0;
    load0      = 1'b0;
    out_fire   = 1'b0;
    case (state_q)
      S_IDLE: begin
        // hold off requests while in reset
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = (walk_op && ready_q) ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        cctl.shift = 1'b1;
        if (step_q == STEP_W'(TABLE_DEPTH - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_fire   = 1'b1;
          state_next = S_IDLE;
          case (req_q.mode)
            MODE_INIT: begin
              cctl.clear = 1'b1;
              load0      = 1'b1;
            end
            MODE_ADD: begin
              cctl.commit    = ready_q;
              cctl.commit_ok = !dup_q && placed_q;
            end
            MODE_CLEAR: begin
              cctl.clear = ready_q;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result of the finished request
  always_comb begin
    status_next = STAT_OK;
    count_next  = count_q;
    ready_next  = ready_q;
    f_hi        = '0;
    f_lo        = '0;
    f_addr      = '0;
    case (req_q.mode)
      MODE_INIT: begin
        count_next = COUNT_W'(1);
        ready_next = 1'b1;
      end
      MODE_ADD: begin
        if (!ready_q) begin
          status_next = STAT_NOT_INIT;
        end else if (dup_q) begin
          status_next = STAT_DUPLICATE;
        end else if (!placed_q) begin
          status_next = STAT_FULL;
        end else begin
          count_next = COUNT_W'(count_q + 1'b1);
        end
      end
      MODE_FIND_ID, MODE_FIND_ADDR: begin
        if (!ready_q) begin
          status_next = STAT_NOT_INIT;
        end else if (find_hit_q) begin
          f_hi   = fnd_hi_q;
          f_lo   = fnd_lo_q;
          f_addr = fnd_addr_q;
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      MODE_DELETE: begin
        if (!ready_q) begin
          status_next = STAT_NOT_INIT;
        end else if (del_hit_q) begin
          count_next = COUNT_W'(count_q - 1'b1);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      MODE_CLEAR: begin
        if (!ready_q) begin
          status_next = STAT_NOT_INIT;
        end else begin
          count_next = '0;
          ready_next = 1'b0;
        end
      end
      default: begin
        status_next = STAT_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_q    <= 1'b0;
      count_q    <= '0;
      step_q     <= '0;
      dup_q      <= 1'b0;
      placed_q   <= 1'b0;
      find_hit_q <= 1'b0;
      del_hit_q  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        step_q     <= '0;
        dup_q      <= 1'b0;
        placed_q   <= 1'b0;
        find_hit_q <= 1'b0;
        del_hit_q  <= 1'b0;
      end else if (state_q == S_WALK) begin
        step_q    <= step_q + 1'b1;
        dup_q     <= dup_q | hit.id_hit | hit.addr_hit;
        placed_q  <= placed_q | hit.place;
        del_hit_q <= del_hit_q | (hit.id_hit && !hctl.local_slot);
        if (((req_q.mode == MODE_FIND_ID) && hit.id_hit) ||
            ((req_q.mode == MODE_FIND_ADDR) && hit.addr_hit)) begin
          find_hit_q <= 1'b1;
        end
      end
      if (out_fire) begin
        ready_q  <= ready_next;
        count_q  <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q <= req_in;
    end
    if ((state_q == S_WALK) &&
        (((req_q.mode == MODE_FIND_ID) && hit.id_hit) ||
         ((req_q.mode == MODE_FIND_ADDR) && hit.addr_hit))) begin
      fnd_hi_q   <= cell_q[0].id_hi;
      fnd_lo_q   <= cell_q[0].id_lo;
      fnd_addr_q <= cell_q[0].addr;
    end
    if (out_fire) begin
      m_tdata <= OUT_DATA_W'({MCOUNT_W'(count_next), f_addr, f_lo, f_hi});
      m_tuser <= status_next;
    end
  end

endmodule

// File: rtl/mtc_cell.sv
// ----------------------------------------------------------------------------
// mtc_cell: one slot of the rotating member table
// Holds one entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module mtc_cell
  import mtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       load,
  input  req_t       load_req,
  input  entry_t     shift_in,
  output entry_t     q
);

  logic              valid;
  logic              pend;
  logic [ID_W-1:0]   id_hi;
  logic [ID_W-1:0]   id_lo;
  logic [ADDR_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pend  <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      pend  <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
      pend  <= 1'b0;
    end else if (ctrl.commit) begin
      // promote the tentative slot only when the add went through
      valid <= valid | (pend & ctrl.commit_ok);
      pend  <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= shift_in.valid;
      pend  <= shift_in.pend;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id_hi <= load_req.id_hi;
      id_lo <= load_req.id_lo;
      addr  <= load_req.addr;
    end else if (ctrl.shift) begin
      id_hi <= shift_in.id_hi;
      id_lo <= shift_in.id_lo;
      addr  <= shift_in.addr;
    end
  end

  assign q = '{valid: valid, pend: pend, id_hi: id_hi, id_lo: id_lo, addr: addr};

endmodule

// File: rtl/mtc_head.sv
// ----------------------------------------------------------------------------
// mtc_head: comparator at the head of the ring
// Matches the head entry against the request and edits it on its way round.
// ----------------------------------------------------------------------------
module mtc_head
  import mtc_pkg::*;
(
  input  entry_t     head,
  input  req_t       req,
  input  head_ctrl_t hctl,
  output hit_t       hit,
  output entry_t     wrap
);

  logic id_eq;
  logic addr_eq;
  logic place;

  assign id_eq   = (head.id_hi == req.id_hi) && (head.id_lo == req.id_lo);
  assign addr_eq = (head.addr == req.addr);

  // first free non-local slot takes the new entry, still invalid until commit
  assign place = (req.mode == MODE_ADD) && !head.valid && !head.pend &&
                 !hctl.local_slot && !hctl.placed;

  assign hit.id_hit   = head.valid && id_eq;
  assign hit.addr_hit = head.valid && addr_eq;
  assign hit.place    = place;

  always_comb begin
    wrap = head;
    if ((req.mode == MODE_DELETE) && head.valid && id_eq && !hctl.local_slot) begin
      wrap.valid = 1'b0;
    end
    if (place) begin
      wrap.pend  = 1'b1;
      wrap.id_hi = req.id_hi;
      wrap.id_lo = req.id_lo;
      wrap.addr  = req.addr;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for member_table_cam_top
// Drives table operations on the request stream and keeps a shadow table that
// works out the reply to each accepted request. A short scripted part covers
// the edge cases. Random episodes follow: each one inits the table and then
// runs add-heavy mixes aimed at live entries, so the table fills up, finds
// hit and miss, and deletes land. Each reply is compared field by field in
// order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import mtc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [ID_W-1:0]   ID_ONES       = '1;
  localparam logic [ADDR_W-1:0] ADDR_ONES     = '1;
  localparam int ITEM_TARGET = 650;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 2 * TABLE_DEPTH + 4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_hi;
    logic [ID_W-1:0]     id_lo;
    logic [ADDR_W-1:0]   addr;
    logic [MCOUNT_W-1:0] members;
  } reply_t;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     hi;
    logic [ID_W-1:0]     lo;
    logic [ADDR_W-1:0]   addr;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [MCOUNT_W-1:0] members;
  } script_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_HOLD
  } rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  member_table_cam_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the member table
  bit              tbl_ready;
  bit              slot_used [TABLE_DEPTH];
  bit [ID_W-1:0]   slot_hi   [TABLE_DEPTH];
  bit [ID_W-1:0]   slot_lo   [TABLE_DEPTH];
  bit [ADDR_W-1:0] slot_addr [TABLE_DEPTH];
  int              members;

  // ids added lately, kept to find and delete after they are gone
  bit [ID_W-1:0]   recent_hi   [8];
  bit [ID_W-1:0]   recent_lo   [8];
  bit [ADDR_W-1:0] recent_addr [8];
  int              recent_wr;

  reply_t      replies_due[$];
  script_row_t script [25];

  int requests_sent;
  int replies_checked;
  int fault_count;
  int burst_left;
  int quiet_cycles;
  int op_tally   [8];
  int stat_tally [8];

  rx_style_t rx_style = RX_OPEN;
  int        rx_left;

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_hi[i]   = '0;
      slot_lo[i]   = '0;
      slot_addr[i] = '0;
    end
    members = 0;
  endfunction

  function automatic int slot_of_id(input int from, input logic [ID_W-1:0] hi,
                                    input logic [ID_W-1:0] lo);
    for (int i = from; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_hi[i] == hi && slot_lo[i] == lo) return i;
    return -1;
  endfunction

  function automatic int slot_of_addr(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_addr[i] == addr) return i;
    return -1;
  endfunction

  // apply one operation to the shadow table and return its reply
  function automatic reply_t apply_table_op(input logic [MODE_W-1:0] mode,
                                            input logic [ID_W-1:0] hi,
                                            input logic [ID_W-1:0] lo,
                                            input logic [ADDR_W-1:0] addr);
    reply_t r;
    int     k;
    r = '0;
    r.status = STAT_OK;
    k = -1;
    if (mode == MODE_INIT) begin
      wipe_table();
      slot_used[0] = 1'b1;
      slot_hi[0]   = hi;
      slot_lo[0]   = lo;
      slot_addr[0] = addr;
      members      = 1;
      tbl_ready    = 1'b1;
    end else if (mode > MODE_CLEAR) begin
      r.status = STAT_NOT_FOUND;
    end else if (!tbl_ready) begin
      r.status = STAT_NOT_INIT;
    end else if (mode == MODE_ADD) begin
      // duplicate check comes ahead of the full check
      if (slot_of_id(0, hi, lo) >= 0 || slot_of_addr(addr) >= 0) begin
        r.status = STAT_DUPLICATE;
      end else begin
        for (int i = 1; i < TABLE_DEPTH; i++)
          if (!slot_used[i] && k < 0) k = i;
        if (k < 0) begin
          r.status = STAT_FULL;
        end else begin
          slot_used[k] = 1'b1;
          slot_hi[k]   = hi;
          slot_lo[k]   = lo;
          slot_addr[k] = addr;
          members++;
        end
      end
    end else if (mode == MODE_FIND_ID || mode == MODE_FIND_ADDR) begin
      k = (mode == MODE_FIND_ID) ? slot_of_id(0, hi, lo) : slot_of_addr(addr);
      if (k < 0) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        r.id_hi = slot_hi[k];
        r.id_lo = slot_lo[k];
        r.addr  = slot_addr[k];
      end
    end else if (mode == MODE_DELETE) begin
      // the local entry in slot 0 is never removed
      k = slot_of_id(1, hi, lo);
      if (k < 0) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        slot_used[k] = 1'b0;
        if (members > 0) members--;
      end
    end else begin
      wipe_table();
      tbl_ready = 1'b0;
    end
    r.members = MCOUNT_W'(members);
    return r;
  endfunction

  function automatic int pick_member();
    int start;
    int idx;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      idx = (start + i) % TABLE_DEPTH;
      if (slot_used[idx]) return idx;
    end
    return -1;
  endfunction

  task automatic push_req(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] hi,
                          input logic [ID_W-1:0] lo, input logic [ADDR_W-1:0] addr,
                          input bit typed, input reply_t typed_reply);
    reply_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {addr, lo, hi};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_table_op(mode, hi, lo, addr);
    op_tally[mode]++;
    stat_tally[r.status]++;
    replies_due.push_back(typed ? typed_reply : r);
    requests_sent++;
    if (mode == MODE_ADD && r.status == STAT_OK) begin
      recent_hi[recent_wr]   = hi;
      recent_lo[recent_wr]   = lo;
      recent_addr[recent_wr] = addr;
      recent_wr = (recent_wr + 1) % 8;
    end
    // drop valid only at the end of a burst
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_op();
    int               pick;
    int               aim;
    int               k;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   hi;
    logic [ID_W-1:0]   lo;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    aim  = $urandom_range(0, 99);
    hi   = {$urandom, $urandom};
    lo   = {$urandom, $urandom};
    addr = $urandom;
    k    = pick_member();
    if (pick < 45) mode = MODE_ADD;
    else if (pick < 60) mode = MODE_FIND_ID;
    else if (pick < 75) mode = MODE_FIND_ADDR;
    else if (pick < 93) mode = MODE_DELETE;
    else if (pick < 96) mode = MODE_INIT;
    else if (pick < 98) mode = MODE_CLEAR;
    else mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;

    if (mode == MODE_ADD) begin
      // mostly fresh entries; some clash on id, address or only the upper id half
      if (k >= 0 && aim < 12) begin
        hi = slot_hi[k];
        lo = slot_lo[k];
      end else if (k >= 0 && aim < 22) begin
        addr = slot_addr[k];
      end else if (k >= 0 && aim < 32) begin
        hi = slot_hi[k];
      end else if (aim < 40) begin
        k  = $urandom_range(0, 7);
        hi = recent_hi[k];
        lo = recent_lo[k];
        addr = recent_addr[k];
      end
    end else if (mode != MODE_INIT) begin
      if (k >= 0 && aim < 70) begin
        hi   = slot_hi[k];
        lo   = slot_lo[k];
        addr = slot_addr[k];
      end else if (aim < 88) begin
        k    = $urandom_range(0, 7);
        hi   = recent_hi[k];
        lo   = recent_lo[k];
        addr = recent_addr[k];
      end
    end
    push_req(mode, hi, lo, addr, 1'b0, '0);
  endtask

  // reply side: stall in a style that is picked anew whenever its run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left  <= $urandom_range(4, 48);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_OPEN:   m_tready <= 1'b1;
      RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= 1'b0;
    endcase
  end

  function automatic void check_field(input string field, input logic [ID_W-1:0] want,
                                      input logic [ID_W-1:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("reply %0d %s: expected %h, got %h", replies_checked, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("reply with no request outstanding: status %0d data %h", m_tuser, m_tdata);
      end else begin
        want = replies_due.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("found_id_high", want.id_hi, m_tdata[63:0]);
        check_field("found_id_low", want.id_lo, m_tdata[127:64]);
        check_field("found_address", want.addr, m_tdata[159:128]);
        check_field("member_count", want.members, m_tdata[164:160]);
        replies_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("member_table_cam_top: mismatch");
      $finish;
    end
  end

  initial begin
    reply_t typed_reply;
    int     run_len;
    script = '{
      '{MODE_ADD,       64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_INIT,  5'd0},
      '{MODE_FIND_ID,   64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_INIT,  5'd0},
      '{MODE_FIND_ADDR, 64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_INIT,  5'd0},
      '{MODE_DELETE,    64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_INIT,  5'd0},
      '{MODE_CLEAR,     64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_INIT,  5'd0},
      '{MODE_SPARE_LO,  64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_FOUND, 5'd0},
      '{MODE_SPARE_HI,  ID_ONES, ID_ONES, ADDR_ONES, 1'b1, STAT_NOT_FOUND, 5'd0},
      '{MODE_INIT,      ID_ONES, ID_ONES, ADDR_ONES, 1'b1, STAT_OK,        5'd1},
      // init on a ready table starts over
      '{MODE_INIT,      64'd0,   64'd0,   32'd0,     1'b1, STAT_OK,        5'd1},
      '{MODE_ADD,       64'd0,   64'd0,   32'd5,     1'b1, STAT_DUPLICATE, 5'd1},
      '{MODE_ADD,       64'd1,   64'd0,   32'd0,     1'b1, STAT_DUPLICATE, 5'd1},
      '{MODE_ADD,       ID_ONES, ID_ONES, ADDR_ONES, 1'b1, STAT_OK,        5'd2},
      // ids that differ from the local one in one half only
      '{MODE_ADD,       64'd0,   64'd1,   32'd7,     1'b1, STAT_OK,        5'd3},
      '{MODE_ADD,       64'd1,   64'd0,   32'd8,     1'b1, STAT_OK,        5'd4},
      '{MODE_FIND_ID,   ID_ONES, ID_ONES, 32'd0,     1'b0, STAT_OK,        5'd0},
      '{MODE_FIND_ADDR, 64'd0,   64'd0,   32'd7,     1'b0, STAT_OK,        5'd0},
      '{MODE_FIND_ADDR, ID_ONES, ID_ONES, 32'd0,     1'b0, STAT_OK,        5'd0},
      '{MODE_FIND_ID,   64'd2,   64'd2,   32'd0,     1'b1, STAT_NOT_FOUND, 5'd4},
      '{MODE_FIND_ADDR, 64'd0,   64'd0,   32'd9,     1'b1, STAT_NOT_FOUND, 5'd4},
      // the local entry cannot be deleted
      '{MODE_DELETE,    64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_FOUND, 5'd4},
      '{MODE_DELETE,    64'd0,   64'd1,   32'd0,     1'b1, STAT_OK,        5'd3},
      '{MODE_DELETE,    64'd0,   64'd1,   32'd0,     1'b1, STAT_NOT_FOUND, 5'd3},
      '{MODE_SPARE_HI,  64'd0,   64'd0,   32'd0,     1'b1, STAT_NOT_FOUND, 5'd3},
      '{MODE_CLEAR,     64'd0,   64'd0,   32'd0,     1'b1, STAT_OK,        5'd0},
      '{MODE_FIND_ADDR, 64'd0,   64'd0,   32'd7,     1'b1, STAT_NOT_INIT,  5'd0}
    };
    tbl_ready = 1'b0;
    wipe_table();
    burst_left = $urandom_range(1, 24);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      typed_reply = '0;
      typed_reply.status  = script[i].status;
      typed_reply.members = script[i].members;
      push_req(script[i].mode, script[i].hi, script[i].lo, script[i].addr,
               script[i].typed, typed_reply);
    end
    drain_replies();

    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) drain_replies();
      // now and then send random requests ahead of the init, whatever state the table is in
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) random_op();
      push_req(MODE_INIT, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
               1'b0, '0);
      run_len = $urandom_range(15, 90);
      repeat (run_len) random_op();
    end

    drain_replies();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests: %0d init, %0d add, %0d find, %0d delete, %0d clear, %0d spare",
             requests_sent, op_tally[MODE_INIT], op_tally[MODE_ADD],
             op_tally[MODE_FIND_ID] + op_tally[MODE_FIND_ADDR], op_tally[MODE_DELETE],
             op_tally[MODE_CLEAR], op_tally[MODE_SPARE_LO] + op_tally[MODE_SPARE_HI]);
    $display("Outcomes: %0d ok, %0d not ready, %0d duplicate, %0d full, %0d not found; %0d checked",
             stat_tally[STAT_OK], stat_tally[STAT_NOT_INIT], stat_tally[STAT_DUPLICATE],
             stat_tally[STAT_FULL], stat_tally[STAT_NOT_FOUND], replies_checked);
    if (fault_count == 0) begin
      $display("member_table_cam_top: match");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("member_table_cam_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mtc_pkg.sv
rtl/mtc_cell.sv
rtl/mtc_head.sv
rtl/member_table_cam_top.sv
bench/tb.sv
